### rtl/core/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
// No dependencies; imported by every other file of the block but bale_ram.
`default_nettype none

package bale_pkg;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	localparam logic [2:0] KIND_CLEAR  = 3'd0;
	localparam logic [2:0] KIND_INSERT = 3'd1;
	localparam logic [2:0] KIND_DELETE = 3'd2;
	localparam logic [2:0] KIND_LOCATE = 3'd3;
	localparam logic [2:0] KIND_FETCH  = 3'd4;
	localparam logic [2:0] KIND_SORTED = 3'd5;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_RANGE    = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_SCAN   = 8'b0000_0100,
		S_SHUP   = 8'b0000_1000,
		S_SHDN   = 8'b0001_0000,
		S_RD     = 8'b0010_0000,
		S_RDW    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

endpackage

`default_nettype wire

### rtl/core/bounded_array_list_engine_unit.sv
// Clear, rejections and unused kinds go straight to the result; retrieve reads one entry;
// locate scans from the front; insert and delete move the entries from the position to the
// end, and sorted insert scans for its place and then shifts. One item at a time: the next
// item is taken only once the result of the last is in the output register. The RAM walk
// reads one entry and writes one per cycle; a held result stalls input.
// Reset clears the element count and the control state; the list storage is not cleared.
`default_nettype none

module bounded_array_list_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [2:0] kind, [34:3] value, [38:35] position, [39] zero
	input  wire logic [bale_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [1:0] status, [33:2] value_out, [37:34] index_out, [42:38] count_out, [47:43] zero
	output logic      [bale_pkg::M_TDATA_W-1:0] m_tdata
);

	import bale_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 4) ? CW : 4;
	localparam int YW = (CW > 5) ? CW : 5;

	state_t state_q;
	logic [2:0]        kind_q;
	logic [31:0]       val_q;
	logic [3:0]        pos_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     tgt_q;
	logic [CW-1:0]     ra_q;
	logic [AW-1:0]     wa_q;
	logic              pend_q;
	logic [1:0]        res_status_q;
	logic [31:0]       res_value_q;
	logic [3:0]        res_index_q;
	logic              o_valid_q;
	logic [1:0]        o_status_q;
	logic [31:0]       o_value_q;
	logic [3:0]        o_index_q;
	logic [4:0]        o_count_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [31:0]       wdata;
	logic [AW-1:0]     raddr;
	logic [31:0]       rdata;
	cmp_res_t          cmp_res;

	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     ra_x;
	logic [XW-1:0]     tgt_x;
	logic [YW-1:0]     cnt_y;
	logic [CW-1:0]     ptr_dec;
	logic              full;
	logic              match;

	assign pos_x   = XW'(pos_q);
	assign cnt_x   = XW'(count_q);
	assign ra_x    = XW'(ra_q);
	assign tgt_x   = XW'(tgt_q);
	assign cnt_y   = YW'(count_q);
	assign ptr_dec = ptr_q - CW'(1);
	assign full    = (count_q == CW'(CAPACITY));
	assign match   = (kind_q == KIND_LOCATE) ? cmp_res.eq : !cmp_res.lt;

	bale_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	bale_cmp u_cmp (
		.a  (rdata),
		.b  (val_q),
		.res(cmp_res)
	);

	always_comb begin
		we    = 1'b0;
		waddr = wa_q;
		wdata = rdata;
		raddr = ptr_q[AW-1:0];
		unique case (state_q)
			S_SHUP: begin
				if (pend_q) begin
					we = 1'b1;
				end else if (ptr_q <= tgt_q) begin
					we    = 1'b1;
					waddr = tgt_q[AW-1:0];
					wdata = val_q;
				end
				raddr = ptr_dec[AW-1:0];
			end
			S_SHDN: begin
				we = pend_q;
			end
			S_RD: begin
				raddr = pos_x[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= '0;
			val_q        <= '0;
			pos_q        <= '0;
			count_q      <= '0;
			ptr_q        <= '0;
			tgt_q        <= '0;
			ra_q         <= '0;
			wa_q         <= '0;
			pend_q       <= 1'b0;
			res_status_q <= STAT_OK;
			res_value_q  <= '0;
			res_index_q  <= '0;
			o_valid_q    <= 1'b0;
			o_status_q   <= STAT_OK;
			o_value_q    <= '0;
			o_index_q    <= '0;
			o_count_q    <= '0;
		end else begin
			if (m_tvalid && m_tready && (state_q != S_DONE)) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q       <= s_tdata[2:0];
						val_q        <= s_tdata[34:3];
						pos_q        <= s_tdata[38:35];
						res_status_q <= STAT_OK;
						res_value_q  <= '0;
						res_index_q  <= '0;
						pend_q       <= 1'b0;
						state_q      <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (kind_q)
						KIND_CLEAR: begin
							count_q <= '0;
							state_q <= S_DONE;
						end
						KIND_INSERT: begin
							if (full) begin
								res_status_q <= STAT_FULL;
								state_q      <= S_DONE;
							end else if (pos_x > cnt_x) begin
								res_status_q <= STAT_RANGE;
								state_q      <= S_DONE;
							end else begin
								tgt_q   <= pos_x[CW-1:0];
								ptr_q   <= count_q;
								state_q <= S_SHUP;
							end
						end
						KIND_DELETE: begin
							if (pos_x >= cnt_x) begin
								res_status_q <= STAT_RANGE;
								state_q      <= S_DONE;
							end else begin
								ptr_q   <= pos_x[CW-1:0] + CW'(1);
								state_q <= S_SHDN;
							end
						end
						KIND_LOCATE: begin
							ptr_q   <= '0;
							state_q <= S_SCAN;
						end
						KIND_FETCH: begin
							if (pos_x >= cnt_x) begin
								res_status_q <= STAT_RANGE;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_RD;
							end
						end
						KIND_SORTED: begin
							if (full) begin
								res_status_q <= STAT_FULL;
								state_q      <= S_DONE;
							end else begin
								ptr_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					if (pend_q && match) begin
						pend_q <= 1'b0;
						if (kind_q == KIND_LOCATE) begin
							res_index_q <= ra_x[3:0];
							state_q     <= S_DONE;
						end else begin
							tgt_q   <= ra_q;
							ptr_q   <= count_q;
							state_q <= S_SHUP;
						end
					end else if (ptr_q < count_q) begin
						ra_q   <= ptr_q;
						ptr_q  <= ptr_q + CW'(1);
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else if (kind_q == KIND_LOCATE) begin
						res_status_q <= STAT_NOTFOUND;
						state_q      <= S_DONE;
					end else begin
						tgt_q   <= count_q;
						ptr_q   <= count_q;
						state_q <= S_SHUP;
					end
				end
				S_SHUP: begin
					if (ptr_q > tgt_q) begin
						wa_q   <= ptr_q[AW-1:0];
						ptr_q  <= ptr_dec;
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						count_q     <= count_q + CW'(1);
						res_index_q <= tgt_x[3:0];
						state_q     <= S_DONE;
					end
				end
				S_SHDN: begin
					if (ptr_q < count_q) begin
						wa_q   <= ptr_dec[AW-1:0];
						ptr_q  <= ptr_q + CW'(1);
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					res_value_q <= rdata;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!o_valid_q || m_tready) begin
						o_valid_q  <= 1'b1;
						o_status_q <= res_status_q;
						o_value_q  <= res_value_q;
						o_index_q  <= res_index_q;
						o_count_q  <= cnt_y[4:0];
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = o_valid_q;
	assign m_tdata  = {5'd0, o_count_q, o_index_q, o_value_q, o_status_q};

endmodule

`default_nettype wire

### rtl/core/bale_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/bale_cmp.sv
// Shared compare unit: equality and signed less-than of a stored entry against the key.
// Depends on bale_pkg.
`default_nettype none

module bale_cmp (
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output bale_pkg::cmp_res_t      res
);

	import bale_pkg::*;

	always_comb begin
		res.eq = (a == b);
		res.lt = (a < b);
	end

endmodule

`default_nettype wire

### rtl/core/bale_chk.sv
// Port-level checker for the bounded array list engine, bound to the top level.
// Depends on bale_pkg and bounded_array_list_engine_unit.
`default_nettype none

module bale_chk #(
	parameter int CAPACITY = 16
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [bale_pkg::S_TDATA_W-1:0] s_tdata,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [bale_pkg::M_TDATA_W-1:0] m_tdata
);

	import bale_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAPACITY > 31) || (m_tdata[42:38] <= 5'(CAPACITY)))
		else $error("count beyond capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == STAT_FULL) |->
			(CAPACITY > 31) || (m_tdata[42:38] == 5'(CAPACITY)))
		else $error("list full reported below capacity");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != STAT_OK) |->
			(m_tdata[33:2] == 32'd0) && (m_tdata[37:34] == 4'd0))
		else $error("rejected item carries value or index");

endmodule

bind bounded_array_list_engine_unit bale_chk #(
	.CAPACITY(CAPACITY)
) u_bale_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

### verif/bounded_array_list_engine_unit_test.sv
// Self-checking testbench for bounded_array_list_engine_unit: a directed stimulus table, then
// random list traffic; each result is checked against its table row or an in-bench model.
// Depends on bale_pkg and the RTL of the block only.
`default_nettype none

module bounded_array_list_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bale_pkg::*;

	localparam int CAP = 16;
	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [3:0]  index;
		logic [4:0]  count;
	} list_result_t;

	typedef struct packed {
		logic [2:0]   kind;
		logic [31:0]  value;
		logic [3:0]   pos;
		bit           typed;
		list_result_t res;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	logic signed [31:0] list_vals [CAP];
	int                 list_len = 0;
	list_result_t       pending_results [$];
	int                 errors = 0;
	int                 inputs_taken = 0;
	int                 results_checked = 0;
	int                 kind_seen [8];
	int                 status_seen [4];
	int                 cycle_count = 0;
	bit                 steady_flow = 1'b0;

	stim_row_t directed_rows [30] = '{
		'{KIND_FETCH,  32'h0000_0000, 4'd0,  1'b1, '{STAT_RANGE, 32'h0, 4'd0, 5'd0}},
		'{KIND_DELETE, 32'h0000_0000, 4'd0,  1'b1, '{STAT_RANGE, 32'h0, 4'd0, 5'd0}},
		'{KIND_LOCATE, 32'h0000_0000, 4'd0,  1'b1, '{STAT_NOTFOUND, 32'h0, 4'd0, 5'd0}},
		'{KIND_INSERT, 32'h0000_0007, 4'd1,  1'b1, '{STAT_RANGE, 32'h0, 4'd0, 5'd0}},
		'{KIND_INSERT, 32'h7FFF_FFFF, 4'd0,  1'b1, '{STAT_OK, 32'h0, 4'd0, 5'd1}},
		'{KIND_INSERT, 32'h8000_0000, 4'd0,  1'b1, '{STAT_OK, 32'h0, 4'd0, 5'd2}},
		'{KIND_FETCH,  32'h0000_0000, 4'd1,  1'b1, '{STAT_OK, 32'h7FFF_FFFF, 4'd0, 5'd2}},
		'{KIND_SORTED, 32'h0000_0000, 4'd0,  1'b1, '{STAT_OK, 32'h0, 4'd1, 5'd3}},
		'{KIND_SORTED, 32'h0000_0000, 4'd9,  1'b0, '0},
		'{KIND_SORTED, 32'hFFFF_FFFF, 4'd0,  1'b0, '0},
		'{KIND_LOCATE, 32'h0000_0000, 4'd0,  1'b0, '0},
		'{KIND_INSERT, 32'h0000_0005, 4'd5,  1'b0, '0},
		'{KIND_SORTED, 32'h8000_0000, 4'd0,  1'b0, '0},
		'{KIND_SORTED, 32'h7FFF_FFFF, 4'd15, 1'b0, '0},
		'{KIND_SORTED, 32'd100,       4'd0,  1'b0, '0},
		'{KIND_SORTED, -32'sd100,     4'd0,  1'b0, '0},
		'{KIND_SORTED, 32'd3,         4'd0,  1'b0, '0},
		'{KIND_SORTED, 32'd42,        4'd0,  1'b0, '0},
		'{KIND_SORTED, -32'sd7,       4'd0,  1'b0, '0},
		'{KIND_SORTED, 32'd1000,      4'd0,  1'b0, '0},
		'{KIND_SORTED, 32'd12,        4'd0,  1'b0, '0},
		'{KIND_SORTED, 32'd9,         4'd0,  1'b0, '0},
		'{KIND_INSERT, 32'h0000_0001, 4'd0,  1'b1, '{STAT_FULL, 32'h0, 4'd0, 5'd16}},
		'{KIND_SORTED, 32'h0000_0001, 4'd3,  1'b1, '{STAT_FULL, 32'h0, 4'd0, 5'd16}},
		'{KIND_FETCH,  32'h0000_0000, 4'd15, 1'b0, '0},
		'{KIND_DELETE, 32'h0000_0000, 4'd15, 1'b0, '0},
		'{KIND_FETCH,  32'h0000_0000, 4'd15, 1'b1, '{STAT_RANGE, 32'h0, 4'd0, 5'd15}},
		'{KIND_SPARE6, 32'hFFFF_FFFF, 4'd15, 1'b1, '{STAT_OK, 32'h0, 4'd0, 5'd15}},
		'{KIND_SPARE7, 32'hAAAA_AAAA, 4'd10, 1'b1, '{STAT_OK, 32'h0, 4'd0, 5'd15}},
		'{KIND_CLEAR,  32'h0000_0000, 4'd0,  1'b1, '{STAT_OK, 32'h0, 4'd0, 5'd0}}
	};

	bounded_array_list_engine_unit #(
		.CAPACITY(CAP)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t timeout with %0d results outstanding", $time, pending_results.size());
		$display("[bounded_array_list_engine_unit] ERROR");
		$finish;
	end

	function automatic void open_slot(input int pos, input logic [31:0] value);
		int i;
		for (i = list_len; i > pos; i--)
			list_vals[i] = list_vals[i - 1];
		list_vals[pos] = value;
		list_len++;
	endfunction

	function automatic list_result_t apply_request(input logic [2:0] kind,
			input logic [31:0] value, input logic [3:0] pos);
		list_result_t res;
		int           i;
		res = '0;
		case (kind)
			KIND_CLEAR: begin
				list_len = 0;
			end
			KIND_INSERT: begin
				if (list_len >= CAP)
					res.status = STAT_FULL;
				else if (int'(pos) > list_len)
					res.status = STAT_RANGE;
				else begin
					open_slot(int'(pos), value);
					res.index = pos;
				end
			end
			KIND_DELETE: begin
				if (int'(pos) >= list_len)
					res.status = STAT_RANGE;
				else begin
					for (i = int'(pos); i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end
			end
			KIND_LOCATE: begin
				res.status = STAT_NOTFOUND;
				for (i = list_len - 1; i >= 0; i--) begin
					if (list_vals[i] == value) begin
						res.status = STAT_OK;
						res.index = i[3:0];
					end
				end
			end
			KIND_FETCH: begin
				if (int'(pos) >= list_len)
					res.status = STAT_RANGE;
				else
					res.value = list_vals[pos];
			end
			KIND_SORTED: begin
				if (list_len >= CAP)
					res.status = STAT_FULL;
				else begin
					i = 0;
					while (i < list_len && list_vals[i] < $signed(value))
						i++;
					open_slot(i, value);
					res.index = i[3:0];
				end
			end
			default: begin
			end
		endcase
		res.count = list_len[4:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (steady_flow || r < 65)
			return 0;
		else if (r < 88)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(12, 4);
		else
			return $urandom_range(60, 20);
	endfunction

	task automatic send_item(input logic [2:0] kind, input logic [31:0] value,
			input logic [3:0] pos, input bit typed, input list_result_t typed_res);
		list_result_t predicted;
		int           gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, pos, value, kind};
		do @(posedge clk); while (!s_tready);
		predicted = apply_request(kind, value, pos);
		pending_results.push_back(typed ? typed_res : predicted);
		inputs_taken++;
		kind_seen[kind]++;
	endtask

	task automatic draw_request(input int mode, output logic [2:0] kind,
			output logic [31:0] value, output logic [3:0] pos);
		int r;
		int a, b, c, d, e;
		case (mode)
			0: begin a = 35; b = 70; c = 78; d = 86; e = 95; end
			1: begin a = 8;  b = 16; c = 56; d = 72; e = 95; end
			default: begin a = 20; b = 40; c = 60; d = 75; e = 94; end
		endcase
		r = $urandom_range(99);
		if (r < a)
			kind = KIND_INSERT;
		else if (r < b)
			kind = KIND_SORTED;
		else if (r < c)
			kind = KIND_DELETE;
		else if (r < d)
			kind = KIND_LOCATE;
		else if (r < e)
			kind = KIND_FETCH;
		else if (r < 99)
			kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
		else
			kind = KIND_CLEAR;

		r = $urandom_range(99);
		if (r < 40)
			value = $urandom;
		else if (r < 70)
			value = $urandom_range(16) - 8;
		else if (r < 80) begin
			case ($urandom_range(3))
				0: value = 32'h8000_0000;
				1: value = 32'h7FFF_FFFF;
				2: value = 32'h0000_0000;
				default: value = 32'hFFFF_FFFF;
			endcase
		end else if (list_len > 0)
			value = list_vals[$urandom_range(list_len - 1)];
		else
			value = $urandom;

		if ($urandom_range(4) == 0)
			pos = 4'($urandom_range(15));
		else if (kind == KIND_INSERT)
			pos = 4'($urandom_range(list_len > 15 ? 15 : list_len));
		else if ((kind == KIND_DELETE || kind == KIND_FETCH) && list_len > 0)
			pos = 4'($urandom_range(list_len - 1));
		else
			pos = 4'($urandom_range(15));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[1:0], m_tdata[33:2], m_tdata[37:34], m_tdata[42:38]};
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: expected none, got %0h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("value_out", want.value, got.value);
				check_field("index_out", 32'(want.index), 32'(got.index));
				check_field("count_out", 32'(want.count), 32'(got.count));
				results_checked++;
				status_seen[got.status]++;
			end
		end
	end

	initial begin
		bit held_off;
		int stall_left;
		held_off = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!held_off && inputs_taken >= 80) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin
		logic [2:0]  kind;
		logic [31:0] value;
		logic [3:0]  pos;
		int          n;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < $size(directed_rows); n++)
			send_item(directed_rows[n].kind, directed_rows[n].value, directed_rows[n].pos,
				directed_rows[n].typed, directed_rows[n].res);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady_flow = ((n / 50) % 4 == 2);
			draw_request((n / 40) % 3, kind, value, pos);
			send_item(kind, value, pos, 1'b0, '0);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		steady_flow = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("items: %0d clear, %0d insert, %0d delete, %0d locate, %0d retrieve, %0d sorted,",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5]);
		$display("%0d unused kind; %0d results checked (ok %0d, full %0d, range %0d, absent %0d)",
			kind_seen[6] + kind_seen[7], results_checked, status_seen[0], status_seen[1],
			status_seen[2], status_seen[3]);
		if (errors == 0)
			$display("[bounded_array_list_engine_unit] OK");
		else
			$display("[bounded_array_list_engine_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/core/bale_pkg.sv
rtl/core/bale_ram.sv
rtl/core/bale_cmp.sv
rtl/core/bounded_array_list_engine_unit.sv
rtl/core/bale_chk.sv
verif/bounded_array_list_engine_unit_test.sv
